/* src/two_axis_move_ratio_planner_macros.svh */
// ----------------------------------------------------------------------------
// Two-axis move ratio planner: assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef TWO_AXIS_MOVE_RATIO_PLANNER_MACROS_SVH
`define TWO_AXIS_MOVE_RATIO_PLANNER_MACROS_SVH

// property holds at every edge
`define TAMRP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define TAMRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/tamrp_pkg.sv */
// ----------------------------------------------------------------------------
// tamrp_pkg
// Types, codes and constants shared by the move ratio planner modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tamrp_pkg;

    localparam int DISP_BITS_DEF = 16;

    localparam int MODE_W      = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 15;
    localparam int TILE_DIST_W = 14;
    localparam int DIAG_DIST_W = 15;
    localparam int CNT_W       = 15;
    localparam int POS_W       = 16;

    localparam logic [TILE_DIST_W-1:0] TILE_DIST_RESET = 14'd2545;
    localparam logic [DIAG_DIST_W-1:0] DIAG_DIST_RESET = 15'd6673;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TILE_DISTANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIAG_DISTANCE = 2'd1;

    // move commands
    localparam logic [MODE_W-1:0] MODE_RAW     = 4'd0;
    localparam logic [MODE_W-1:0] MODE_UP      = 4'd1;
    localparam logic [MODE_W-1:0] MODE_DOWN    = 4'd2;
    localparam logic [MODE_W-1:0] MODE_RIGHT   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_LEFT    = 4'd4;
    localparam logic [MODE_W-1:0] MODE_DIAG_XP = 4'd5;
    localparam logic [MODE_W-1:0] MODE_DIAG_YP = 4'd6;
    localparam logic [MODE_W-1:0] MODE_DIAG_YN = 4'd7;
    localparam logic [MODE_W-1:0] MODE_DIAG_XN = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_G_CHECK,
        ST_DIV_X,
        ST_DIV_Y,
        ST_PUBLISH
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic gcd_step;
        logic gcd_finish;
        logic div_start_x;
        logic div_start_y;
        logic div_step;
        logic save_s1;
        logic save_s2;
        logic publish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic gcd_done;
        logic div_busy;
        logic null_g;
    } ctrl_status_t;

endpackage

`default_nettype wire

/* src/tamrp_ifs.sv */
// ----------------------------------------------------------------------------
// tamrp channel interfaces
// Move command, plan result and register write channels, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface tamrp_cmd_if
    import tamrp_pkg::*;
#(
    parameter int DISP_BITS = DISP_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [MODE_W-1:0]           mode;
    logic signed [DISP_BITS-1:0] disp_x;
    logic signed [DISP_BITS-1:0] disp_y;

    modport source (output valid, mode, disp_x, disp_y, input ready);
    modport sink (input valid, mode, disp_x, disp_y, output ready);
endinterface

interface tamrp_plan_if
    import tamrp_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic                    dir_one;
    logic                    dir_two;
    logic [CNT_W-1:0]        rounds;
    logic [CNT_W-1:0]        steps_one;
    logic [CNT_W-1:0]        steps_two;
    logic signed [POS_W-1:0] tile_col;
    logic signed [POS_W-1:0] tile_row;
    logic                    null_move;

    modport source (output valid, dir_one, dir_two, rounds, steps_one, steps_two,
                    tile_col, tile_row, null_move, input ready);
    modport sink (input valid, dir_one, dir_two, rounds, steps_one, steps_two,
                  tile_col, tile_row, null_move, output ready);
endinterface

interface tamrp_cfg_if
    import tamrp_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/tamrp_ctrl.sv */
// ----------------------------------------------------------------------------
// tamrp_ctrl
// Sequencer: accept, binary GCD, two shared-divider passes (skipped for a zero GCD), publish.
// ----------------------------------------------------------------------------
`default_nettype none
`include "two_axis_move_ratio_planner_macros.svh"

module tamrp_ctrl
    import tamrp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    input  wire ctrl_status_t status,
    output ctrl_cmd_t         cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_GCD;
            end
            ST_GCD:
            begin
                if (status.gcd_done)
                    state_next = ST_G_CHECK;
            end
            ST_G_CHECK:
            begin
                state_next = status.null_g ? ST_PUBLISH : ST_DIV_X;
            end
            ST_DIV_X:
            begin
                if (!status.div_busy)
                    state_next = ST_DIV_Y;
            end
            ST_DIV_Y:
            begin
                if (!status.div_busy)
                    state_next = ST_PUBLISH;
            end
            ST_PUBLISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_GCD:
            begin
                cmd.gcd_step   = !status.gcd_done;
                cmd.gcd_finish = status.gcd_done;
            end
            ST_G_CHECK:
            begin
                cmd.div_start_x = !status.null_g;
            end
            ST_DIV_X:
            begin
                cmd.div_step    = status.div_busy;
                cmd.save_s1     = !status.div_busy;
                cmd.div_start_y = !status.div_busy;
            end
            ST_DIV_Y:
            begin
                cmd.div_step = status.div_busy;
                cmd.save_s2  = !status.div_busy;
            end
            ST_PUBLISH:
            begin
                cmd.publish = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.publish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;

    `TAMRP_ASSERT_NEXT(a_accept_starts_gcd, in_valid && in_ready, state_reg == ST_GCD, "accepted item did not start the GCD")
    `TAMRP_ASSERT_NEXT(a_publish_shows_item, cmd.publish, out_valid_reg, "published item not shown on the output")
    `TAMRP_ASSERT(a_no_overwrite, (out_valid_reg && !out_ready) |-> !cmd.publish, "waiting output item overwritten")

endmodule

`default_nettype wire

/* src/tamrp_datapath.sv */
// ----------------------------------------------------------------------------
// tamrp_datapath
// Move decode, tile position, binary GCD unit, restoring divider, output regs.
// ----------------------------------------------------------------------------
`default_nettype none
`include "two_axis_move_ratio_planner_macros.svh"

module tamrp_datapath
    import tamrp_pkg::*;
#(
    parameter int DISP_BITS = DISP_BITS_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ctrl_cmd_t                   cmd,
    output ctrl_status_t                     status,
    input  wire logic                        cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_DATA_W-1:0]       cfg_data,
    input  wire logic [MODE_W-1:0]           in_mode,
    input  wire logic signed [DISP_BITS-1:0] in_disp_x,
    input  wire logic signed [DISP_BITS-1:0] in_disp_y,
    output logic                             out_dir_one,
    output logic                             out_dir_two,
    output logic [CNT_W-1:0]                 out_rounds,
    output logic [CNT_W-1:0]                 out_steps_one,
    output logic [CNT_W-1:0]                 out_steps_two,
    output logic signed [POS_W-1:0]          out_tile_col,
    output logic signed [POS_W-1:0]          out_tile_row,
    output logic                             out_null_move
);

    localparam int MAG_W = (DISP_BITS - 1 > DIAG_DIST_W) ? DISP_BITS - 1 : DIAG_DIST_W;
    localparam int SH_W  = $clog2(MAG_W + 1);

    // magnitude of a signed displacement, most negative value saturates
    function automatic logic [MAG_W-1:0] mag_of(input logic [DISP_BITS-1:0] v);
        logic [DISP_BITS-1:0] neg;
        logic [MAG_W-1:0]     m;
        neg = ~v + 1'b1;
        if (!v[DISP_BITS-1])
            m = MAG_W'(v);
        else if (v == {1'b1, {(DISP_BITS-1){1'b0}}})
            m = MAG_W'({1'b0, {(DISP_BITS-1){1'b1}}});
        else
            m = MAG_W'(neg);
        return m;
    endfunction

    logic [TILE_DIST_W-1:0] tile_dist_reg;
    logic [DIAG_DIST_W-1:0] diag_dist_reg;
    logic [POS_W-1:0]       col_reg;
    logic [POS_W-1:0]       col_next;
    logic [POS_W-1:0]       row_reg;
    logic [POS_W-1:0]       row_next;

    logic [MAG_W-1:0] mx_next;
    logic [MAG_W-1:0] my_next;
    logic             px_next;
    logic             py_next;

    logic [MAG_W-1:0] mx_reg;
    logic [MAG_W-1:0] my_reg;
    logic             dir_one_reg;
    logic             dir_two_reg;

    logic [MAG_W-1:0] a_reg;
    logic [MAG_W-1:0] a_next;
    logic [MAG_W-1:0] b_reg;
    logic [MAG_W-1:0] b_next;
    logic [SH_W-1:0]  k_reg;
    logic [SH_W-1:0]  k_next;
    logic [MAG_W-1:0] g_reg;
    logic [MAG_W-1:0] g_next;

    logic [MAG_W-1:0] quo_reg;
    logic [MAG_W-1:0] quo_next;
    logic [MAG_W-1:0] rem_reg;
    logic [MAG_W-1:0] rem_next;
    logic [SH_W-1:0]  div_cnt_reg;
    logic [MAG_W:0]   rem_shift;
    logic [MAG_W+1:0] rem_diff;

    logic [CNT_W-1:0] s1_reg;
    logic [CNT_W-1:0] s2_reg;

    logic                    out_dir_one_reg;
    logic                    out_dir_two_reg;
    logic [CNT_W-1:0]        out_rounds_reg;
    logic [CNT_W-1:0]        out_steps_one_reg;
    logic [CNT_W-1:0]        out_steps_two_reg;
    logic [POS_W-1:0]        out_tile_col_reg;
    logic [POS_W-1:0]        out_tile_row_reg;
    logic                    out_null_move_reg;

    // ---------------- registers and tile position ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_dist_reg <= TILE_DIST_RESET;
            diag_dist_reg <= DIAG_DIST_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_TILE_DISTANCE)
                tile_dist_reg <= cfg_data[TILE_DIST_W-1:0];
            if (cfg_we && cfg_index == REG_DIAG_DISTANCE)
                diag_dist_reg <= cfg_data[DIAG_DIST_W-1:0];
            if (cmd.load)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // ---------------- move decode ----------------
    always_comb
    begin
        mx_next  = '0;
        my_next  = '0;
        px_next  = 1'b0;
        py_next  = 1'b0;
        col_next = col_reg;
        row_next = row_reg;
        unique case (in_mode)
            MODE_RAW:
            begin
                mx_next = mag_of(in_disp_x);
                my_next = mag_of(in_disp_y);
                px_next = !in_disp_x[DISP_BITS-1];
                py_next = !in_disp_y[DISP_BITS-1];
            end
            MODE_UP:
            begin
                mx_next  = MAG_W'(tile_dist_reg);
                my_next  = MAG_W'(tile_dist_reg);
                px_next  = 1'b1;
                py_next  = 1'b1;
                row_next = row_reg + 1'b1;
            end
            MODE_DOWN:
            begin
                mx_next  = MAG_W'(tile_dist_reg);
                my_next  = MAG_W'(tile_dist_reg);
                row_next = row_reg - 1'b1;
            end
            MODE_RIGHT:
            begin
                mx_next  = MAG_W'(tile_dist_reg);
                my_next  = MAG_W'(tile_dist_reg);
                px_next  = 1'b1;
                col_next = col_reg - 1'b1;
            end
            MODE_LEFT:
            begin
                mx_next  = MAG_W'(tile_dist_reg);
                my_next  = MAG_W'(tile_dist_reg);
                py_next  = 1'b1;
                col_next = col_reg + 1'b1;
            end
            MODE_DIAG_XP:
            begin
                mx_next = MAG_W'(diag_dist_reg);
                px_next = 1'b1;
            end
            MODE_DIAG_YP:
            begin
                my_next = MAG_W'(diag_dist_reg);
                py_next = 1'b1;
            end
            MODE_DIAG_YN:
            begin
                my_next = MAG_W'(diag_dist_reg);
            end
            MODE_DIAG_XN:
            begin
                mx_next = MAG_W'(diag_dist_reg);
            end
            default:
            begin
                mx_next = '0;
            end
        endcase
    end

    // ---------------- binary GCD step ----------------
    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        k_next = k_reg;
        if (!a_reg[0] && !b_reg[0])
        begin
            a_next = a_reg >> 1;
            b_next = b_reg >> 1;
            k_next = k_reg + 1'b1;
        end
        else if (!a_reg[0])
            a_next = a_reg >> 1;
        else if (!b_reg[0])
            b_next = b_reg >> 1;
        else if (a_reg >= b_reg)
            a_next = (a_reg - b_reg) >> 1;
        else
            b_next = (b_reg - a_reg) >> 1;
    end

    assign g_next = (a_reg | b_reg) << k_reg;

    // ---------------- restoring divide step ----------------
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[MAG_W-1]};
        rem_diff  = {1'b0, rem_shift} - {2'b00, g_reg};
        if (!rem_diff[MAG_W+1])
        begin
            rem_next = rem_diff[MAG_W-1:0];
            quo_next = {quo_reg[MAG_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_shift[MAG_W-1:0];
            quo_next = {quo_reg[MAG_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (cmd.div_start_x || cmd.div_start_y)
            div_cnt_reg <= SH_W'(MAG_W);
        else if (cmd.div_step)
            div_cnt_reg <= div_cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mx_reg      <= mx_next;
            my_reg      <= my_next;
            dir_one_reg <= px_next && (mx_next != '0);
            dir_two_reg <= py_next && (my_next != '0);
            a_reg       <= mx_next;
            b_reg       <= my_next;
            k_reg       <= '0;
            s1_reg      <= '0;
            s2_reg      <= '0;
        end
        else if (cmd.gcd_step)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            k_reg <= k_next;
        end

        if (cmd.gcd_finish)
            g_reg <= g_next;

        if (cmd.save_s1)
            s1_reg <= quo_reg[CNT_W-1:0];
        if (cmd.save_s2)
            s2_reg <= quo_reg[CNT_W-1:0];

        if (cmd.div_start_x)
        begin
            quo_reg <= mx_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_start_y)
        begin
            quo_reg <= my_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end

        if (cmd.publish)
        begin
            out_dir_one_reg   <= dir_one_reg;
            out_dir_two_reg   <= dir_two_reg;
            out_rounds_reg    <= g_reg[CNT_W-1:0];
            out_steps_one_reg <= s1_reg;
            out_steps_two_reg <= s2_reg;
            out_tile_col_reg  <= col_reg;
            out_tile_row_reg  <= row_reg;
            out_null_move_reg <= (g_reg == '0);
        end
    end

    assign status.gcd_done = (a_reg == '0) || (b_reg == '0);
    assign status.div_busy = (div_cnt_reg != '0);
    assign status.null_g   = (g_reg == '0);

    assign out_dir_one   = out_dir_one_reg;
    assign out_dir_two   = out_dir_two_reg;
    assign out_rounds    = out_rounds_reg;
    assign out_steps_one = out_steps_one_reg;
    assign out_steps_two = out_steps_two_reg;
    assign out_tile_col  = out_tile_col_reg;
    assign out_tile_row  = out_tile_row_reg;
    assign out_null_move = out_null_move_reg;

    `TAMRP_ASSERT(a_divisor_nonzero, (cmd.div_start_x || cmd.div_start_y) |-> (g_reg != '0), "divider started with a zero divisor")
    `TAMRP_ASSERT(a_exact_quotient, (cmd.save_s1 || cmd.save_s2) |-> (rem_reg == '0), "step count division left a remainder")
    `TAMRP_ASSERT_NEXT(a_null_iff_still, cmd.gcd_finish, (g_reg == '0) == ((mx_reg == '0) && (my_reg == '0)), "zero GCD does not match a still move")

endmodule

`default_nettype wire

/* src/two_axis_move_ratio_planner.sv */
// ----------------------------------------------------------------------------
// two_axis_move_ratio_planner
// Plans a two-motor move: direction bits, GCD rounds and steps per round.
//
// cmd  : move item, mode (raw pair or tile command) and raw displacements.
// plan : result item, one per move, held in an output register until taken.
// cfg  : register writes (tile_distance, diag_distance), always ready;
//        the user must write only while no move is in flight (unenforced).
// Per item: accept, a binary GCD, then two passes of one shared restoring
// divider, plus sequencing; magnitudes are W = max(DISP_BITS-1, 15) bits
// wide. The divider passes are skipped for a move with no motion. One
// move is worked at a time; cmd.ready is high only while the sequencer
// is idle.
// A finished item waits in the output register while the next move is
// accepted and worked; if plan.ready stays low the sequencer holds the
// new result until the register frees.
// Reset restores the register reset values and clears the tile position.
// ----------------------------------------------------------------------------
`default_nettype none

module two_axis_move_ratio_planner
    import tamrp_pkg::*;
#(
    parameter int DISP_BITS = DISP_BITS_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    tamrp_cmd_if.sink    cmd,
    tamrp_plan_if.source plan,
    tamrp_cfg_if.sink    cfg
);

    ctrl_cmd_t    ctrl_cmd;
    ctrl_status_t ctrl_status;

    assign cfg.ready = 1'b1;

    tamrp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (plan.valid),
        .out_ready (plan.ready),
        .status    (ctrl_status),
        .cmd       (ctrl_cmd)
    );

    tamrp_datapath #(
        .DISP_BITS (DISP_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (ctrl_cmd),
        .status        (ctrl_status),
        .cfg_we        (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .in_mode       (cmd.mode),
        .in_disp_x     (cmd.disp_x),
        .in_disp_y     (cmd.disp_y),
        .out_dir_one   (plan.dir_one),
        .out_dir_two   (plan.dir_two),
        .out_rounds    (plan.rounds),
        .out_steps_one (plan.steps_one),
        .out_steps_two (plan.steps_two),
        .out_tile_col  (plan.tile_col),
        .out_tile_row  (plan.tile_row),
        .out_null_move (plan.null_move)
    );

endmodule

`default_nettype wire
